// ===== rtl/core/nvmeqp_pkg.sv =====
// Shared types and constants for the NVMe host queue-pair engine.
`default_nettype none

package nvmeqp_pkg;

  localparam int ADMIN_QUEUE_DEPTH = 32;
  localparam int IO_QUEUE_DEPTH    = 64;

  localparam int PTR_W    = 6;
  localparam int ADDR_W   = 48;
  localparam int STRIDE_W = 4;
  localparam int STATUS_W = 11;
  localparam int WORD_W   = 16;
  localparam int CFG_IDX_W = 8;

  localparam logic [PTR_W-1:0] ADMIN_LAST = PTR_W'(ADMIN_QUEUE_DEPTH - 1);
  localparam logic [PTR_W-1:0] IO_LAST    = PTR_W'(IO_QUEUE_DEPTH - 1);

  localparam logic [ADDR_W-1:0] DOORBELL_OFFSET = ADDR_W'(32'h1000);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BASE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE = CFG_IDX_W'(1);

  typedef enum logic {
    OP_SUBMIT   = 1'b0,
    OP_COMPLETE = 1'b1
  } op_t;

  // Result item, lowest field in the lowest bits, padded to 80 bits.
  typedef struct packed {
    logic [5:0]          pad;
    logic                error;
    logic [STATUS_W-1:0] status_code;
    logic                completion_taken;
    logic [PTR_W-1:0]    doorbell_value;
    logic [ADDR_W-1:0]   doorbell_address;
    logic                doorbell_write;
    logic [PTR_W-1:0]    slot_index;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/nvme_host_queue_pair_engine_top.sv =====
// Throughput: one item per cycle while the skid entry is free; pointer update and
// doorbell address sum sit between the input handshake and a two-entry output stage
// (result plus skid). The slave side stays ready while the skid entry is free, so a
// stalled result does not block the next transfer.
// Reset: tails and heads go to zero, expected phases to one, register base and stride to zero.
`default_nettype none

module nvme_host_queue_pair_engine_top
  import nvmeqp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Configuration write channel.
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ADDR_W-1:0]    cfg_data,
  // Input items.
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [WORD_W-1:0]    s_tdata,  // completion_status
  input  wire logic [1:0]           s_tuser,  // op, queue_select
  // Result items.
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // slot_index, doorbell_write, doorbell_address, doorbell_value,
  // completion_taken, status_code, error, zero padding
  output logic [79:0]               m_tdata
);

  logic [ADDR_W-1:0]   register_base;
  logic [STRIDE_W-1:0] doorbell_stride;

  logic [PTR_W-1:0] submit_tail      [2];
  logic [PTR_W-1:0] completion_head  [2];
  logic             completion_phase [2];

  result_t out_data;
  result_t skid_data;
  logic    out_valid;
  logic    skid_valid;

  logic             accept;
  op_t              op;
  logic             q;
  logic [WORD_W-1:0] word;
  logic [PTR_W-1:0] last;
  logic [PTR_W-1:0] tail_next;
  logic [PTR_W-1:0] head_next;
  logic             phase_ok;
  logic [1:0]       db_index;
  logic [4:0]       db_shift;
  logic [ADDR_W-1:0] db_addr;
  result_t          res;

  assign cfg_ready = 1'b1;
  assign s_tready  = !skid_valid;
  assign accept    = s_tvalid && s_tready;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;

  assign op   = op_t'(s_tuser[0]);
  assign q    = s_tuser[1];
  assign word = s_tdata;
  assign last = q ? IO_LAST : ADMIN_LAST;

  // State never leaves 0..depth-1, so the modulo is a compare against the last slot.
  assign tail_next = (submit_tail[q] == last) ? '0 : submit_tail[q] + PTR_W'(1);
  assign head_next = (completion_head[q] == last) ? '0 : completion_head[q] + PTR_W'(1);
  assign phase_ok  = (word[0] == completion_phase[q]);

  // Doorbell slot 2*q + c, spaced 4 << stride bytes apart.
  assign db_index = {q, op == OP_COMPLETE};
  assign db_shift = {1'b0, doorbell_stride} + 5'd2;
  assign db_addr  = register_base + DOORBELL_OFFSET + (ADDR_W'(db_index) << db_shift);

  always_comb begin
    res = '0;
    unique case (op)
      OP_SUBMIT: begin
        res.slot_index       = submit_tail[q];
        res.doorbell_write   = 1'b1;
        res.doorbell_address = db_addr;
        res.doorbell_value   = tail_next;
      end
      OP_COMPLETE: begin
        if (phase_ok) begin
          res.doorbell_write   = 1'b1;
          res.doorbell_address = db_addr;
          res.doorbell_value   = head_next;
          res.completion_taken = 1'b1;
          res.status_code      = word[STATUS_W:1];
          res.error            = (word[STATUS_W:1] != '0);
        end
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      register_base   <= '0;
      doorbell_stride <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_BASE) begin
        register_base <= cfg_data;
      end else if (cfg_index == REG_STRIDE) begin
        doorbell_stride <= cfg_data[STRIDE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        submit_tail[i]      <= '0;
        completion_head[i]  <= '0;
        completion_phase[i] <= 1'b1;
      end
    end else if (accept) begin
      if (op == OP_SUBMIT) begin
        submit_tail[q] <= tail_next;
      end else if (phase_ok) begin
        completion_head[q] <= head_next;
        if (head_next == '0) begin
          completion_phase[q] <= !completion_phase[q];
        end
      end
    end
  end

  // Output register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept) begin
        out_data <= res;
      end
    end else if (accept) begin
      skid_data <= res;
    end
  end

  // The skid entry is only filled behind a held result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid with empty output register");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (submit_tail[0] <= ADMIN_LAST) && (completion_head[0] <= ADMIN_LAST))
    else $error("admin queue pointer beyond queue depth");

  a_submit_moves_tail: assert property (@(posedge clk) disable iff (rst)
    accept && (op == OP_SUBMIT) && !q |=> submit_tail[0] != $past(submit_tail[0]))
    else $error("admin submission tail did not advance");

  a_taken_rings: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.completion_taken |-> out_data.doorbell_write &&
    (out_data.slot_index == '0))
    else $error("consumed completion without doorbell write");

  a_phase_flip_on_wrap: assert property (@(posedge clk) disable iff (rst)
    completion_phase[1] != $past(completion_phase[1]) |-> completion_head[1] == '0)
    else $error("I/O completion phase changed without head wrap");

endmodule

`default_nettype wire
